### hw/rtl/calo_adc_bank_unpacker_unit_assert.svh
// assertion macros shared by the unpacker modules
`ifndef CALO_ADC_BANK_UNPACKER_UNIT_ASSERT_SVH
`define CALO_ADC_BANK_UNPACKER_UNIT_ASSERT_SVH

// implication checked on every edge outside reset
`define CABU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle
`define CABU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cabu_pkg.sv
package cabu_pkg;

    typedef struct packed {
        logic [31:0] bank_word;
        logic        first_of_bank;
        logic        last_of_bank;
        logic [2:0]  bank_version;
    } cabu_in_t;

    typedef struct packed {
        logic signed [15:0] adc_value;
        logic [15:0]        channel_or_id;
        logic [8:0]         card_code;
        logic               is_status;
        logic [1:0]         bank_status;
        logic               last_result;
    } cabu_out_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_BODY     = 3'd1,
        PH_CARD     = 3'd2,
        PH_TRIG     = 3'd3,
        PH_PATTERN  = 3'd4,
        PH_DATA     = 3'd5,
        PH_STRADDLE = 3'd6
    } cabu_phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BADVER    = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [2:0] VER_ONE   = 3'd1;
    localparam logic [2:0] VER_TWO   = 3'd2;
    localparam logic [2:0] VER_THREE = 3'd3;

    // output register status toward the decoder
    typedef struct packed {
        logic busy;
        logic take;
    } cabu_obuf_stat_t;

endpackage

### hw/rtl/calo_adc_bank_unpacker_unit.sv
// Readout bank unpacker: takes one 32-bit bank word per request and returns the
// decoded ADC values, then one status result at the end of every bank. A new word
// is taken only once the previous one is fully decoded, and a result cannot leave
// the decoder while the previous load is still reaching the output register
// (version 2 walks its packed channel stream one 4-bit or 12-bit code per result
// through a shift register). Header, trigger and pattern words yield no result.
// The single output register lets a finished result wait while decoding stalls
// on it.
module calo_adc_bank_unpacker_unit
    import cabu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // configuration: skip_first_word
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    // bank words
    input  logic      in_valid,
    output logic      in_ready,
    input  cabu_in_t  in_item,
    // decoded results
    output logic      res_valid,
    input  logic      res_ready,
    output cabu_out_t res
);

    cabu_obuf_stat_t obuf_stat;
    logic            load;
    cabu_out_t       load_data;

    // decode sequencer with the nibble shift register
    cabu_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .obuf      (obuf_stat),
        .load      (load),
        .load_data (load_data)
    );

    // result holding register
    cabu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (load_data),
        .stat      (obuf_stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

### hw/rtl/cabu_out_reg.sv
module cabu_out_reg
    import cabu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  cabu_out_t load_data,
    output cabu_obuf_stat_t stat,
    output logic      res_valid,
    input  logic      res_ready,
    output cabu_out_t res
);

    `include "calo_adc_bank_unpacker_unit_assert.svh"

    logic      valid_reg;
    cabu_out_t data_reg;

    assign stat.busy = valid_reg && !res_ready;
    assign stat.take = valid_reg && res_ready;
    assign res_valid = valid_reg;
    assign res       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    `CABU_ASSERT_IMP(a_no_overwrite, load, !(valid_reg && !res_ready), "result overwritten")
    `CABU_ASSERT_NEXT(a_load_valid, load, valid_reg, "loaded result not shown")
    `CABU_ASSERT_IMP(a_status_clean, valid_reg && data_reg.is_status,
        data_reg.adc_value == 16'sd0, "status carries a value")

endmodule

### hw/rtl/cabu_decoder.sv
module cabu_decoder
    import cabu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  cabu_in_t        in_item,
    input  cabu_obuf_stat_t obuf,
    output logic            load,
    output cabu_out_t       load_data
);

    `include "calo_adc_bank_unpacker_unit_assert.svh"

    typedef enum logic [1:0] {
        S_WAIT,
        S_WORK,
        S_STATUS
    } seq_t;

    seq_t        seq_reg;
    cabu_phase_t phase_reg;
    logic        skip_cfg_reg;
    logic [2:0]  ver_reg;
    logic [5:0]  skip_left_reg;
    logic [31:0] pattern_reg;
    logic [31:0] buf_reg;      // shifts right past each code as it is decoded
    logic [5:0]  offset_reg;
    logic [5:0]  chan_reg;
    logic [6:0]  items_reg;
    logic [11:0] partial_reg;
    logic [8:0]  code_reg;
    logic        saw_reg;
    logic        last_reg;
    logic        half_reg;
    logic [3:0]  lsh_reg;      // nibbles already in partial

    // a load still on its way to the output register blocks the next one
    logic        can_load;
    assign can_load  = !obuf.busy && !load;
    assign cfg_ready = (seq_reg == S_WAIT);
    assign in_ready  = (seq_reg == S_WAIT);

    logic accept;
    assign accept = in_valid && in_ready;

    // long/short code fields from the head of the buffer
    logic [11:0] long_raw;
    logic [3:0]  short_raw;
    logic        chan_long;
    logic [5:0]  off_short;
    logic [5:0]  off_long;
    logic [5:0]  off_next;
    logic        next_long;
    logic [11:0] strad_raw;
    logic [15:0] v3_item;
    assign long_raw  = buf_reg[11:0];
    assign short_raw = buf_reg[3:0];
    assign chan_long = pattern_reg[chan_reg[4:0]];
    assign off_short = offset_reg + 6'd4;
    assign off_long  = offset_reg + 6'd12;
    assign off_next  = chan_long ? off_long : off_short;
    // whether the code after this one is a long code
    assign next_long = pattern_reg[chan_reg[4:0] + 5'd1];
    assign v3_item   = half_reg ? buf_reg[31:16] : buf_reg[15:0];
    always_comb
    begin
        unique case (lsh_reg)
            4'd1:    strad_raw = {buf_reg[7:0], 4'h0} | partial_reg;
            4'd2:    strad_raw = {buf_reg[3:0], 8'h0} | partial_reg;
            default: strad_raw = buf_reg[11:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_WAIT;
            phase_reg     <= PH_IDLE;
            skip_cfg_reg  <= 1'b0;
            ver_reg       <= 3'd0;
            skip_left_reg <= 6'd0;
            pattern_reg   <= 32'd0;
            buf_reg       <= 32'd0;
            offset_reg    <= 6'd0;
            chan_reg      <= 6'd0;
            items_reg     <= 7'd0;
            partial_reg   <= 12'd0;
            code_reg      <= 9'd0;
            saw_reg       <= 1'b0;
            last_reg      <= 1'b0;
            half_reg      <= 1'b0;
            lsh_reg       <= 4'd0;
            load          <= 1'b0;
            load_data     <= '0;
        end
        else
        begin
            load <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                skip_cfg_reg <= cfg_data;
            end
            unique case (seq_reg)
                S_WAIT:
                begin
                    if (accept)
                    begin
                        last_reg <= in_item.last_of_bank;
                        half_reg <= 1'b0;
                        if (in_item.first_of_bank)
                        begin
                            ver_reg       <= in_item.bank_version;
                            skip_left_reg <= 6'd0;
                            pattern_reg   <= 32'd0;
                            offset_reg    <= 6'd0;
                            chan_reg      <= 6'd0;
                            items_reg     <= 7'd0;
                            partial_reg   <= 12'd0;
                            code_reg      <= 9'd0;
                            phase_reg     <= (in_item.bank_version == VER_TWO ||
                                              in_item.bank_version == VER_THREE)
                                             ? PH_CARD : PH_BODY;
                            buf_reg       <= in_item.bank_word;
                            saw_reg       <= !skip_cfg_reg;
                            seq_reg       <= skip_cfg_reg
                                             ? (in_item.last_of_bank ? S_STATUS : S_WAIT)
                                             : S_WORK;
                        end
                        else if (phase_reg != PH_IDLE)
                        begin
                            saw_reg <= 1'b1;
                            if (phase_reg == PH_DATA && ver_reg == VER_TWO
                                && offset_reg < 6'd32)
                            begin
                                // keep the remaining bits of the current word
                                buf_reg <= buf_reg;
                            end
                            else
                            begin
                                buf_reg <= in_item.bank_word;
                            end
                            if (phase_reg == PH_DATA && ver_reg == VER_TWO
                                && offset_reg >= 6'd32)
                            begin
                                offset_reg <= 6'd0;
                            end
                            seq_reg <= S_WORK;
                        end
                    end
                end
                S_WORK:
                begin
                    priority case (phase_reg)
                        PH_BODY:
                        begin
                            if (ver_reg == VER_ONE)
                            begin
                                if (can_load)
                                begin
                                    load <= 1'b1;
                                    load_data.adc_value     <= buf_reg[15:0];
                                    load_data.channel_or_id <= buf_reg[31:16];
                                    load_data.card_code     <= 9'd0;
                                    load_data.is_status     <= 1'b0;
                                    load_data.bank_status   <= ST_OK;
                                    load_data.last_result   <= !last_reg;
                                    seq_reg <= last_reg ? S_STATUS : S_WAIT;
                                end
                            end
                            else
                            begin
                                seq_reg <= last_reg ? S_STATUS : S_WAIT;
                            end
                        end
                        PH_CARD:
                        begin
                            code_reg <= buf_reg[22:14];
                            items_reg <= (ver_reg == VER_THREE) ? buf_reg[13:7] : 7'd0;
                            skip_left_reg <= 6'(({1'b0, buf_reg[6:0]} + 8'd3) >> 2);
                            if (buf_reg[6:0] != 7'd0)
                            begin
                                phase_reg <= PH_TRIG;
                            end
                            else if (ver_reg == VER_TWO)
                            begin
                                phase_reg <= PH_PATTERN;
                            end
                            else
                            begin
                                phase_reg <= (buf_reg[13:7] != 7'd0) ? PH_DATA : PH_CARD;
                            end
                            seq_reg <= last_reg ? S_STATUS : S_WAIT;
                        end
                        PH_TRIG:
                        begin
                            skip_left_reg <= skip_left_reg - 6'd1;
                            if (skip_left_reg == 6'd1)
                            begin
                                if (ver_reg == VER_TWO)
                                begin
                                    phase_reg <= PH_PATTERN;
                                end
                                else
                                begin
                                    phase_reg <= (items_reg != 7'd0) ? PH_DATA : PH_CARD;
                                end
                            end
                            seq_reg <= last_reg ? S_STATUS : S_WAIT;
                        end
                        PH_PATTERN:
                        begin
                            pattern_reg <= buf_reg;
                            offset_reg  <= 6'd32;
                            chan_reg    <= 6'd0;
                            phase_reg   <= PH_DATA;
                            seq_reg     <= last_reg ? S_STATUS : S_WAIT;
                        end
                        PH_DATA:
                        begin
                            if (ver_reg == VER_THREE)
                            begin
                                if (items_reg == 7'd0 || half_reg && items_reg != 7'd0
                                    && 1'b0)
                                begin
                                    seq_reg <= last_reg ? S_STATUS : S_WAIT;
                                end
                                else if (can_load)
                                begin
                                    load <= 1'b1;
                                    load_data.adc_value     <= {6'd0, v3_item[9:0]};
                                    load_data.channel_or_id <= {10'd0, v3_item[15:10]};
                                    load_data.card_code     <= code_reg;
                                    load_data.is_status     <= 1'b0;
                                    load_data.bank_status   <= ST_OK;
                                    items_reg <= items_reg - 7'd1;
                                    half_reg  <= 1'b1;
                                    if (half_reg || items_reg == 7'd1)
                                    begin
                                        load_data.last_result <= !last_reg;
                                        if (items_reg == 7'd1)
                                        begin
                                            phase_reg <= PH_CARD;
                                        end
                                        seq_reg <= last_reg ? S_STATUS : S_WAIT;
                                    end
                                    else
                                    begin
                                        load_data.last_result <= 1'b0;
                                    end
                                end
                            end
                            else if (chan_reg >= 6'd32)
                            begin
                                phase_reg <= PH_CARD;
                                seq_reg <= last_reg ? S_STATUS : S_WAIT;
                            end
                            else if (offset_reg >= 6'd32)
                            begin
                                seq_reg <= last_reg ? S_STATUS : S_WAIT;
                            end
                            else if (chan_long && off_long > 6'd32)
                            begin
                                // long code runs into the next word
                                partial_reg <= long_raw & ((12'd1 << {offset_reg[5:0] == 6'd28
                                    ? 4'd4 : 4'd8}) - 12'd1);
                                lsh_reg    <= (offset_reg == 6'd28) ? 4'd1 : 4'd2;
                                offset_reg <= off_long - 6'd32;
                                phase_reg  <= PH_STRADDLE;
                                seq_reg    <= last_reg ? S_STATUS : S_WAIT;
                            end
                            else if (can_load)
                            begin
                                load <= 1'b1;
                                load_data.channel_or_id <= {10'd0, chan_reg};
                                load_data.card_code     <= code_reg;
                                load_data.is_status     <= 1'b0;
                                load_data.bank_status   <= ST_OK;
                                chan_reg <= chan_reg + 6'd1;
                                if (chan_long)
                                begin
                                    load_data.adc_value <= 16'({4'd0, long_raw}) - 16'd256;
                                    buf_reg    <= {12'd0, buf_reg[31:12]};
                                    offset_reg <= off_long;
                                end
                                else
                                begin
                                    load_data.adc_value <= 16'({12'd0, short_raw}) - 16'd8;
                                    buf_reg    <= {4'd0, buf_reg[31:4]};
                                    offset_reg <= off_short;
                                end
                                // last of the word: card done, word used up, or the
                                // next long code straddles into the next word
                                if (chan_reg == 6'd31 || off_next >= 6'd32
                                    || (next_long && off_next > 6'd20))
                                begin
                                    load_data.last_result <= !last_reg;
                                    if (chan_reg == 6'd31)
                                    begin
                                        phase_reg <= PH_CARD;
                                        seq_reg <= last_reg ? S_STATUS : S_WAIT;
                                    end
                                    else if (off_next >= 6'd32)
                                    begin
                                        seq_reg <= last_reg ? S_STATUS : S_WAIT;
                                    end
                                end
                                else
                                begin
                                    load_data.last_result <= 1'b0;
                                end
                            end
                        end
                        PH_STRADDLE:
                        begin
                            if (can_load)
                            begin
                                load <= 1'b1;
                                load_data.adc_value <= 16'({4'd0, strad_raw}) - 16'd256;
                                load_data.channel_or_id <= {10'd0, chan_reg};
                                load_data.card_code     <= code_reg;
                                load_data.is_status     <= 1'b0;
                                load_data.bank_status   <= ST_OK;
                                chan_reg <= chan_reg + 6'd1;
                                buf_reg  <= (lsh_reg == 4'd1) ? {8'd0, buf_reg[31:8]}
                                                              : {4'd0, buf_reg[31:4]};
                                lsh_reg  <= 4'd0;
                                if (chan_reg == 6'd31)
                                begin
                                    load_data.last_result <= !last_reg;
                                    phase_reg <= PH_CARD;
                                    seq_reg   <= last_reg ? S_STATUS : S_WAIT;
                                end
                                else
                                begin
                                    load_data.last_result <= 1'b0;
                                    phase_reg <= PH_DATA;
                                end
                            end
                        end
                        default:
                        begin
                            seq_reg <= last_reg ? S_STATUS : S_WAIT;
                        end
                    endcase
                end
                S_STATUS:
                begin
                    if (can_load)
                    begin
                        load <= 1'b1;
                        load_data.adc_value     <= 16'sd0;
                        load_data.channel_or_id <= 16'd0;
                        load_data.card_code     <= 9'd0;
                        load_data.is_status     <= 1'b1;
                        load_data.last_result   <= 1'b1;
                        if (!saw_reg)
                        begin
                            load_data.bank_status <= ST_EMPTY;
                        end
                        else if (ver_reg == 3'd0 || ver_reg > VER_THREE)
                        begin
                            load_data.bank_status <= ST_BADVER;
                        end
                        else if (ver_reg != VER_ONE && phase_reg != PH_CARD)
                        begin
                            load_data.bank_status <= ST_TRUNCATED;
                        end
                        else
                        begin
                            load_data.bank_status <= ST_OK;
                        end
                        phase_reg <= PH_IDLE;
                        seq_reg   <= S_WAIT;
                    end
                end
                default:
                begin
                    seq_reg <= S_WAIT;
                end
            endcase
        end
    end

    `CABU_ASSERT_IMP(a_no_accept_busy, seq_reg != S_WAIT, !in_ready, "request taken while busy")
    `CABU_ASSERT_IMP(a_chan_range, seq_reg == S_WORK && phase_reg == PH_STRADDLE,
        chan_reg < 6'd32, "straddle past channel 31")
    `CABU_ASSERT_NEXT(a_status_idle, seq_reg == S_STATUS && can_load, phase_reg == PH_IDLE,
        "bank not closed after status")

endmodule

### tb/calo_adc_bank_unpacker_unit_checker.sv
`timescale 1ns / 1ps
module calo_adc_bank_unpacker_unit_checker
    import cabu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic      cfg_data,
    input  logic      in_valid,
    input  logic      in_ready,
    input  cabu_in_t  in_item,
    input  logic      res_valid,
    input  logic      res_ready,
    input  cabu_out_t res,
    output int        errors,
    output int        pending
);
    // decoder mirror
    logic        skip_hdr;
    cabu_phase_t phase;
    logic [2:0]  ver_held;
    logic [5:0]  trig_left;
    logic [31:0] pattern;
    logic [31:0] word_buf;
    int          bit_pos;
    int          chan_cnt;
    int          adc_left;
    logic [11:0] low_bits;
    logic [8:0]  card;
    logic        had_data;

    cabu_out_t decoded_q[$];
    int        new_cnt;

    assign pending = decoded_q.size();

    function automatic void push_value(int adc, int chan, logic [8:0] code);
        cabu_out_t r;
        r = '0;
        r.adc_value     = adc[15:0];
        r.channel_or_id = chan[15:0];
        r.card_code     = code;
        decoded_q.push_back(r);
        new_cnt++;
    endfunction

    function automatic void after_trig();
        if (ver_held == VER_TWO)
            phase = PH_PATTERN;
        else
            phase = (adc_left != 0) ? PH_DATA : PH_CARD;
    endfunction

    function automatic void walk_channels();
        logic [11:0] raw;
        while (chan_cnt < 32 && bit_pos < 32) begin
            if (!pattern[chan_cnt]) begin
                push_value(int'((word_buf >> bit_pos) & 32'hF) - 8, chan_cnt, card);
                bit_pos += 4;
                chan_cnt++;
            end
            else begin
                raw = 12'((word_buf >> bit_pos) & 32'hFFF);
                bit_pos += 12;
                if (bit_pos > 32) begin
                    low_bits = raw;
                    bit_pos -= 32;
                    phase = PH_STRADDLE;
                    return;
                end
                push_value(int'(raw) - 256, chan_cnt, card);
                chan_cnt++;
            end
        end
        if (chan_cnt >= 32)
            phase = PH_CARD;
    endfunction

    function automatic void decode(logic [31:0] w);
        logic [15:0] half;
        logic [31:0] raw;
        case (phase)
            PH_BODY:
                if (ver_held == VER_ONE)
                    push_value(int'($signed(w[15:0])), int'(w[31:16]), 9'd0);
            PH_CARD:
            begin
                card = w[22:14];
                trig_left = 6'((int'(w[6:0]) + 3) >> 2);
                adc_left = (ver_held == VER_THREE) ? int'(w[13:7]) : 0;
                if (trig_left != 0)
                    phase = PH_TRIG;
                else
                    after_trig();
            end
            PH_TRIG:
            begin
                trig_left = trig_left - 6'd1;
                if (trig_left == 0)
                    after_trig();
            end
            PH_PATTERN:
            begin
                pattern = w;
                bit_pos = 32;
                chan_cnt = 0;
                phase = PH_DATA;
            end
            PH_DATA:
                if (ver_held == VER_THREE) begin
                    for (int h = 0; h < 2 && adc_left != 0; h++) begin
                        half = w[16*h +: 16];
                        push_value(int'(half[9:0]), int'(half[15:10]), card);
                        adc_left--;
                    end
                    if (adc_left == 0)
                        phase = PH_CARD;
                end
                else begin
                    if (bit_pos >= 32) begin
                        word_buf = w;
                        bit_pos = 0;
                    end
                    walk_channels();
                end
            PH_STRADDLE:
            begin
                raw = 32'(low_bits) + ((w << ((12 - bit_pos) & 31)) & 32'hFFF);
                push_value(int'(raw & 32'hFFF) - 256, chan_cnt, card);
                chan_cnt++;
                word_buf = w;
                phase = PH_DATA;
                if (chan_cnt >= 32)
                    phase = PH_CARD;
                else
                    walk_channels();
            end
            default: ;
        endcase
    endfunction

    function automatic void take_word(cabu_in_t it);
        cabu_out_t   s;
        logic        use_it;
        logic [1:0]  st;
        new_cnt = 0;
        use_it = 1'b1;
        if (it.first_of_bank) begin
            ver_held = it.bank_version;
            had_data = 0;
            trig_left = 0;
            pattern = 0;
            word_buf = 0;
            bit_pos = 0;
            chan_cnt = 0;
            adc_left = 0;
            low_bits = 0;
            card = 0;
            phase = (ver_held == VER_TWO || ver_held == VER_THREE) ? PH_CARD : PH_BODY;
            if (skip_hdr)
                use_it = 1'b0;
        end
        else if (phase == PH_IDLE) begin
            return;
        end
        if (use_it) begin
            had_data = 1;
            decode(it.bank_word);
        end
        if (it.last_of_bank) begin
            if (!had_data)
                st = ST_EMPTY;
            else if (ver_held < VER_ONE || ver_held > VER_THREE)
                st = ST_BADVER;
            else if (ver_held != VER_ONE && phase != PH_CARD)
                st = ST_TRUNCATED;
            else
                st = ST_OK;
            s = '0;
            s.is_status = 1'b1;
            s.bank_status = st;
            decoded_q.push_back(s);
            new_cnt++;
            phase = PH_IDLE;
        end
        if (new_cnt > 0)
            decoded_q[decoded_q.size() - 1].last_result = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        cabu_out_t e;
        if (!rst_n) begin
            skip_hdr = 0;
            phase = PH_IDLE;
            ver_held = 0;
            errors = 0;
            decoded_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready)
                skip_hdr = cfg_data;
            if (in_valid && in_ready)
                take_word(in_item);
            if (res_valid && res_ready) begin
                if (decoded_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, res);
                end
                else begin
                    e = decoded_q.pop_front();
                    if (res !== e) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $time, e, res);
                    end
                end
            end
        end
    end
endmodule

### tb/calo_adc_bank_unpacker_unit_tb.sv
`timescale 1ns / 1ps
module calo_adc_bank_unpacker_unit_tb;
    import cabu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    logic      in_valid;
    logic      in_ready;
    cabu_in_t  in_item;
    logic      res_valid;
    logic      res_ready;
    cabu_out_t res;
    int        errors;
    int        pending;
    int        cycles;
    logic      calm;     // no idling in the final stretch
    int        words_sent;

    calo_adc_bank_unpacker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    calo_adc_bank_unpacker_unit_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        res_ready = 0;
        @(posedge rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                res_ready <= 0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            res_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // one bank word request, with optional sender gap before it
    task automatic send_word(logic [31:0] w, logic fb, logic lb, logic [2:0] v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1;
        in_item <= '{bank_word: w, first_of_bank: fb, last_of_bank: lb, bank_version: v};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic end_valid();
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        end_valid();
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_skip(logic val);
        cfg_valid <= 1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // card header: trigger bytes, adc item count, card code
    function automatic logic [31:0] card_hdr(int trig, int n, logic [8:0] code);
        logic [31:0] w;
        w = $urandom();
        w[6:0] = trig[6:0];
        w[13:7] = n[6:0];
        w[22:14] = code;
        return w;
    endfunction

    // well-formed bank of the given version, random content, maybe cut short
    task automatic send_bank(logic [2:0] v, logic hdr, logic cut);
        logic [31:0] q[$];
        int ncards;
        int trig;
        int n;
        if (hdr)
            q.push_back($urandom());
        ncards = $urandom_range(1, 2);
        if (v == VER_ONE || !(v inside {VER_TWO, VER_THREE})) begin
            repeat ($urandom_range(1, 5)) q.push_back($urandom());
        end
        else begin
            repeat (ncards) begin
                trig = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                n = ($urandom_range(0, 9) == 0) ? 127 : $urandom_range(0, 6);
                q.push_back(card_hdr(trig, n, 9'($urandom())));
                repeat ((trig + 3) / 4) q.push_back($urandom());
                if (v == VER_TWO) begin
                    q.push_back($urandom_range(0, 1) ? $urandom() :
                                ($urandom() & $urandom() & $urandom()));
                    // enough words for any pattern, rest taken as next headers
                    repeat (12) q.push_back($urandom());
                end
                else begin
                    repeat ((n + 1) / 2) q.push_back($urandom());
                end
            end
        end
        if (cut && q.size() > 1)
            q = q[0:$urandom_range(0, q.size() - 2)];
        foreach (q[i])
            send_word(q[i], i == 0, i == q.size() - 1, v);
    endtask

    initial
    begin
        logic [2:0] v;
        cycles = 0;
        calm = 0;
        words_sent = 0;
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = 0;
        in_valid = 0;
        in_item = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: stray words, v1 extremes, bad versions, truncation
        send_word(32'hFFFF_FFFF, 0, 1, VER_ONE);
        send_word(32'h0000_8000, 1, 0, VER_ONE);
        send_word(32'h0000_7FFF, 0, 0, VER_ONE);
        send_word(32'hFFFF_0000, 0, 1, VER_ONE);
        send_word(32'h1234_5678, 1, 1, 3'd0);
        send_word(32'hAAAA_5555, 1, 1, 3'd7);
        // v2 all short codes, then all long codes
        send_word(card_hdr(0, 0, 9'h1FF), 1, 0, VER_TWO);
        send_word(32'h0, 0, 0, VER_TWO);
        repeat (4) send_word($urandom(), 0, 0, VER_TWO);
        send_word(card_hdr(4, 0, 9'h0), 0, 0, VER_TWO);
        send_word($urandom(), 0, 0, VER_TWO);
        send_word(32'hFFFF_FFFF, 0, 0, VER_TWO);
        repeat (5) send_word($urandom(), 0, 1, VER_TWO);
        // v3 card with a trigger word, new bank inside a bank
        send_word(card_hdr(1, 3, 9'h0AB), 1, 0, VER_THREE);
        send_word(32'hFFFF_FFFF, 0, 0, VER_THREE);
        send_word(32'hFFFF_0000, 1, 0, VER_THREE);
        send_word(32'h0, 0, 1, VER_THREE);
        wait_drained();

        // random phases over both register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_skip(ph[0]);
            if (ph == 2) begin
                // one-word bank with the header skip off
                send_word($urandom(), 1, 1, VER_TWO);
            end
            while (words_sent < 90 * (ph + 1)) begin
                calm = (ph == 3 && words_sent > 320);
                case ($urandom_range(0, 9))
                    0: send_word($urandom(), $urandom_range(0, 1), $urandom_range(0, 1),
                                 3'($urandom()));
                    1: send_bank(3'($urandom()), ph[0], 0);
                    2: send_bank($urandom_range(0, 1) ? VER_TWO : VER_THREE, ph[0], 1);
                    3: send_bank(VER_ONE, ph[0], 0);
                    default: send_bank($urandom_range(0, 1) ? VER_TWO : VER_THREE,
                                       ph[0], 0);
                endcase
            end
            // sender holds off until every result is back
            wait_drained();
        end

        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
